@@ rtl/ild_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ild_pkg: shared types and constants for the instruction length decoder
// Phase codes, result codes, per-instruction state and opcode byte values.
// ---------------------------------------------------------------------------
package ild_pkg;

    localparam int ILD_MAX_LEN = 15;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_OPCODE = 3'd1,
        PH_MODRM  = 3'd2,
        PH_SIB    = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE       = 2'd0,
        KIND_RIP_DISP32 = 2'd1,
        KIND_REL32      = 2'd2,
        KIND_REL8       = 2'd3
    } fixup_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TWO_BYTE = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Byte values with a fixed meaning
    localparam logic [7:0] OP_OPSIZE = 8'h66;
    localparam logic [7:0] OP_ESCAPE = 8'h0F;
    localparam logic [7:0] OP_CALL32 = 8'hE8;
    localparam logic [7:0] OP_JMP32  = 8'hE9;
    localparam logic [7:0] OP_JMP8   = 8'hEB;
    localparam logic [7:0] OP_GRP3B  = 8'hF6;
    localparam logic [7:0] OP_GRP3V  = 8'hF7;
    localparam logic [3:0] REX_HIGH  = 4'h4;

    typedef struct packed {
        phase_t      phase;
        logic        operand_size_flag;
        logic        rex_w_flag;
        logic [7:0]  opcode;
        logic [2:0]  modrm_reg_field;
        logic [4:0]  byte_count;
        logic [3:0]  bytes_to_skip;
        logic [3:0]  pending_immediate;
        fixup_kind_t kind;
        logic [3:0]  disp_offset;
    } insn_state_t;

    typedef struct packed {
        logic [3:0]  insn_length;
        fixup_kind_t fixup_kind;
        logic [3:0]  disp_offset;
        status_t     status;
    } insn_result_t;

    localparam insn_state_t INSN_STATE_CLEAR = '{
        phase: PH_PREFIX, operand_size_flag: 1'b0, rex_w_flag: 1'b0,
        opcode: 8'h00, modrm_reg_field: 3'd0, byte_count: 5'd0,
        bytes_to_skip: 4'd0, pending_immediate: 4'd0, kind: KIND_NONE,
        disp_offset: 4'd0
    };

endpackage

@@ rtl/ild_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ild_if: valid/ready channels of the instruction length decoder
// One channel carries code bytes, the other carries decode results.
// ---------------------------------------------------------------------------
interface ild_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       restart;

    modport source (output valid, code_byte, restart, input ready);
    modport sink   (input valid, code_byte, restart, output ready);
endinterface

interface ild_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] insn_length;
    logic [1:0] fixup_kind;
    logic [3:0] disp_offset;
    logic [1:0] status;

    modport source (output valid, insn_length, fixup_kind, disp_offset, status,
                    input ready);
    modport sink   (input valid, insn_length, fixup_kind, disp_offset, status,
                    output ready);
endinterface

@@ rtl/ild_decode.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ild_decode: single-byte step of the length decoder
// Work out the next instruction state and any result from one code byte.
// ---------------------------------------------------------------------------
module ild_decode
    import ild_pkg::*;
#(
    parameter int MAX_LEN = ILD_MAX_LEN
)(
    input  insn_state_t  cur_state,
    input  logic [7:0]   code_byte,
    input  logic         restart,
    output insn_state_t  nxt_state,
    output logic         res_valid,
    output insn_result_t res
);

    localparam logic [4:0] MaxLen = 5'(MAX_LEN);

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        return b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
               b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 ||
               b == 8'h64 || b == 8'h65;
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        return (op[7:6] == 2'b00 && !op[2]) ||
               op == 8'h62 || op == 8'h63 || op == 8'h69 || op == 8'h6B ||
               op[7:4] == 4'h8 ||
               op == 8'hC0 || op == 8'hC1 || op == 8'hC6 || op == 8'hC7 ||
               (op >= 8'hD0 && op <= 8'hD3) || op[7:3] == 5'b11011 ||
               op == 8'hF6 || op == 8'hF7 || op == 8'hFE || op == 8'hFF;
    endfunction

    function automatic logic [3:0] immediate_size(input logic [7:0] op,
                                                  input logic osz,
                                                  input logic rexw);
        logic [3:0] word;
        word = osz ? 4'd2 : 4'd4;
        priority if (op[7:6] == 2'b00 && op[2:0] == 3'd4) return 4'd1;
        else if (op[7:6] == 2'b00 && op[2:0] == 3'd5)     return word;
        else if (op[7:3] == 5'b10110)                     return 4'd1;
        else if (op[7:3] == 5'b10111)                     return rexw ? 4'd8 : word;
        else if (op == 8'h6A || op == 8'h6B || op == 8'h80 || op == 8'h82 ||
                 op == 8'h83 || op == 8'hA8 || op == 8'hC0 || op == 8'hC1 ||
                 op == 8'hC6)                             return 4'd1;
        else if (op == 8'hC2 || op == 8'hCA)              return 4'd2;
        else if (op == 8'h68 || op == 8'h69 || op == 8'h81 || op == 8'hA9 ||
                 op == 8'hC7)                             return word;
        else                                              return 4'd0;
    endfunction

    insn_state_t s;
    logic [4:0]  count;
    logic        done;
    logic        escape;
    logic        do_opcode;
    logic        do_address;
    logic [3:0]  disp;
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;

    always_comb
    begin
        s          = restart ? INSN_STATE_CLEAR : cur_state;
        count      = s.byte_count + 5'd1;
        done       = 1'b0;
        escape     = 1'b0;
        do_opcode  = 1'b0;
        do_address = 1'b0;
        disp       = 4'd0;
        mod_f      = code_byte[7:6];
        rm_f       = code_byte[2:0];

        unique case (s.phase)
            PH_OPCODE:
            begin
                do_opcode = 1'b1;
            end
            PH_MODRM:
            begin
                s.modrm_reg_field = code_byte[5:3];
                if (s.opcode == OP_GRP3B)
                    s.pending_immediate = (code_byte[5:3] <= 3'd1) ? 4'd1 : 4'd0;
                else if (s.opcode == OP_GRP3V)
                    s.pending_immediate = (code_byte[5:3] <= 3'd1) ?
                        (s.operand_size_flag ? 4'd2 : 4'd4) : 4'd0;
                if (mod_f == 2'd1)
                    disp = 4'd1;
                else if (mod_f == 2'd2)
                    disp = 4'd4;
                if (mod_f != 2'd3 && rm_f == 3'd4)
                begin
                    s.bytes_to_skip = disp;
                    s.phase         = PH_SIB;
                end
                else
                begin
                    if (mod_f == 2'd0 && rm_f == 3'd5)
                    begin
                        s.kind        = KIND_RIP_DISP32;
                        s.disp_offset = count[3:0];
                        disp          = 4'd4;
                    end
                    do_address = 1'b1;
                end
            end
            PH_SIB:
            begin
                disp = s.bytes_to_skip;
                if (disp == 4'd0 && rm_f == 3'd5)
                    disp = 4'd4;
                do_address = 1'b1;
            end
            PH_SKIP:
            begin
                s.bytes_to_skip = s.bytes_to_skip - 4'd1;
                done            = (s.bytes_to_skip == 4'd0);
            end
            default:
            begin
                // prefix phase; unused codes land here too
                if (code_byte == OP_OPSIZE)
                    s.operand_size_flag = 1'b1;
                else if (is_legacy_prefix(code_byte))
                    s.operand_size_flag = s.operand_size_flag;
                else if (code_byte[7:4] == REX_HIGH)
                begin
                    s.rex_w_flag = code_byte[3];
                    s.phase      = PH_OPCODE;
                end
                else
                    do_opcode = 1'b1;
            end
        endcase

        if (do_opcode)
        begin
            s.opcode = code_byte;
            if (code_byte == OP_ESCAPE)
                escape = 1'b1;
            else if (code_byte == OP_CALL32 || code_byte == OP_JMP32)
            begin
                s.kind          = KIND_REL32;
                s.disp_offset   = count[3:0];
                s.bytes_to_skip = 4'd4;
                s.phase         = PH_SKIP;
            end
            else if (code_byte[7:4] == 4'h7 || code_byte[7:2] == 6'b111000 ||
                     code_byte == OP_JMP8)
            begin
                s.kind          = KIND_REL8;
                s.bytes_to_skip = 4'd1;
                s.phase         = PH_SKIP;
            end
            else
            begin
                s.pending_immediate = immediate_size(code_byte, s.operand_size_flag,
                                                     s.rex_w_flag);
                if (takes_modrm(code_byte))
                    s.phase = PH_MODRM;
                else
                    do_address = 1'b1;
            end
        end

        if (do_address)
        begin
            s.bytes_to_skip = disp + s.pending_immediate;
            if (s.bytes_to_skip == 4'd0)
                done = 1'b1;
            else
                s.phase = PH_SKIP;
        end

        res_valid       = 1'b1;
        res.insn_length = 4'd0;
        res.fixup_kind  = KIND_NONE;
        res.disp_offset = 4'd0;
        res.status      = ST_OK;
        nxt_state       = INSN_STATE_CLEAR;
        priority if (escape)
            res.status = ST_TWO_BYTE;
        else if (done && count <= MaxLen)
        begin
            res.insn_length = count[3:0];
            res.fixup_kind  = s.kind;
            res.disp_offset = s.disp_offset;
        end
        else if (done || count >= MaxLen)
            res.status = ST_OVERFLOW;
        else
        begin
            res_valid    = 1'b0;
            s.byte_count = count;
            nxt_state    = s;
        end
    end

endmodule

@@ rtl/ild_out_reg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ild_out_reg: result register of the length decoder
// Hold one result until the sink takes it.
// ---------------------------------------------------------------------------
module ild_out_reg
    import ild_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  insn_result_t  load_data,
    output logic          free,
    ild_result_if.source  res_out
);

    logic         vld_reg;
    logic         vld_next;
    insn_result_t data_reg;

    assign free     = !vld_reg || res_out.ready;
    assign vld_next = load || (vld_reg && !res_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign res_out.valid       = vld_reg;
    assign res_out.insn_length = data_reg.insn_length;
    assign res_out.fixup_kind  = data_reg.fixup_kind;
    assign res_out.disp_offset = data_reg.disp_offset;
    assign res_out.status      = data_reg.status;

endmodule

@@ rtl/x86_64_insn_length_decoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// x86_64_insn_length_decoder: streaming x86-64 instruction length decoder
// Byte-serial decode of prefixes, REX, opcode, ModR/M, SIB, displacement and
// immediate, with one result word per finished instruction.
// ---------------------------------------------------------------------------
// Code bytes arrive one word per cycle in program order while ready is high;
// a set restart bit drops any partial instruction and starts a new one at
// that byte. The block takes one byte every cycle while not stalled: each
// byte is held in an input register, decoded against the small per-instruction
// state in a single pass, and a finished instruction lands in the result
// register, which offers its result word. That word gives the length,
// the relocation kind (none, rip-relative disp32, rel32 call/jmp, rel8 branch)
// and the offset of the disp32/rel32 field. A 0x0F escape gives an error word
// with status 1; an instruction reaching MAX_LEN bytes unfinished gives
// status 2. After any result word the next byte starts a new instruction.
// Input stalls only while the held byte finishes an instruction, an earlier
// result word still waits in the result register and the sink holds off.
// ---------------------------------------------------------------------------
module x86_64_insn_length_decoder
    import ild_pkg::*;
#(
    parameter int MAX_LEN = ILD_MAX_LEN
)(
    input  logic         clk,
    input  logic         rst_n,
    ild_byte_if.sink     code_in,
    ild_result_if.source insn_out
);

    // input register
    logic        in_vld_reg;
    logic        in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;

    // per-instruction state
    insn_state_t  state_reg;
    insn_state_t  state_next;

    logic         res_valid;
    insn_result_t res;
    logic         out_free;
    logic         advance;

    // advance the held byte unless it makes a result the output cannot take
    assign advance        = in_vld_reg && (!res_valid || out_free);
    assign code_in.ready  = !in_vld_reg || advance;
    assign in_vld_next    = (code_in.valid && code_in.ready) || (in_vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= INSN_STATE_CLEAR;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_in.valid && code_in.ready)
        begin
            in_byte_reg    <= code_in.code_byte;
            in_restart_reg <= code_in.restart;
        end
    end

    ild_decode #(
        .MAX_LEN (MAX_LEN)
    ) u_decode (
        .cur_state (state_reg),
        .code_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .nxt_state (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    ild_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .free      (out_free),
        .res_out   (insn_out)
    );

endmodule
